@@ sv/blr_pkg.sv @@
`default_nettype none

package blr_pkg;

    // fixed widths of the word fields
    localparam int unsigned BOX_COORD_W = 12;
    localparam int unsigned CLASS_W     = 8;

    typedef struct packed {
        logic [BOX_COORD_W-1:0] box_x;
        logic [BOX_COORD_W-1:0] box_y;
        logic [BOX_COORD_W-1:0] box_width;
        logic [BOX_COORD_W-1:0] box_height;
        logic [CLASS_W-1:0]     class_id;
        logic                   last_box;
    } t_box_in;

    typedef struct packed {
        logic [BOX_COORD_W-1:0] out_x;
        logic [BOX_COORD_W-1:0] out_y;
        logic [BOX_COORD_W-1:0] out_width;
        logic [BOX_COORD_W-1:0] out_height;
        logic [CLASS_W-1:0]     out_class;
        logic                   out_last;
        logic                   overflowed;
    } t_box_out;

    // controller to datapath
    typedef struct packed {
        logic ins;  // input word taken: insert or drop
        logic pop;  // output word taken: shift store down by one
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic one;  // exactly one entry left in the store
    } t_status;

endpackage

`default_nettype wire

@@ sv/blr_stream_if.sv @@
`default_nettype none

interface blr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/box_left_to_right_sorter.sv @@
// a box word is taken and inserted into the sorted store at once
// after the marked word, the first sorted word is offered on the next cycle;
// n stored boxes then leave one per cycle while the sink is ready
// the input stalls while the store drains
// the store is a row of compare-and-shift cells, one per entry
// reset (synchronous, active low) empties the store and clears the drop flag
`default_nettype none

module box_left_to_right_sorter #(
    parameter int unsigned MAX_BOXES  = 32,  // store capacity
    parameter int unsigned COORD_BITS = 12   // coordinate precision inside the store
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    blr_stream_if.sink   i_box,   // one box per word, last_box marks the list end
    blr_stream_if.source o_box    // sorted boxes, emitted after the marked word
);

    blr_pkg::t_cmd    w_cmd;
    blr_pkg::t_status w_status;
    logic             w_in_ready;
    logic             w_out_valid;

    // controller: collect words, then drain the store on the marked word
    blr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_box.valid),
        .i_in_last   (i_box.data.last_box),
        .i_out_ready (o_box.ready),
        .i_status    (w_status),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    // datapath: sorted store with parallel key compare, shifts down while draining
    blr_datapath #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_box    (i_box.data),
        .o_status (w_status),
        .o_box    (o_box.data)
    );

    // head of the store is the output register; it holds while the sink stalls
    assign i_box.ready = w_in_ready;
    assign o_box.valid = w_out_valid;

endmodule

`default_nettype wire

@@ sv/blr_ctrl.sv @@
`default_nettype none

module blr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_last,
    input  wire logic            i_out_ready,
    input  blr_pkg::t_status     i_status,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output blr_pkg::t_cmd        o_cmd
);

    typedef enum logic [1:0] {
        S_COLLECT = 2'b01,
        S_DRAIN   = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready  = (r_state == S_COLLECT);
    assign o_out_valid = (r_state == S_DRAIN);
    assign o_cmd.ins   = i_in_valid && o_in_ready;
    assign o_cmd.pop   = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: begin
                if (o_cmd.ins && i_in_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (o_cmd.pop && i_status.one) begin
                    n_state = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ sv/blr_datapath.sv @@
`default_nettype none

module blr_datapath #(
    parameter int unsigned MAX_BOXES  = 32,
    parameter int unsigned COORD_BITS = 12
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  blr_pkg::t_cmd        i_cmd,
    input  blr_pkg::t_box_in     i_box,
    output blr_pkg::t_status     o_status,
    output blr_pkg::t_box_out    o_box
);

    localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);
    localparam int unsigned KEY_W = 4 * COORD_BITS + 2;

    typedef struct packed {
        logic [COORD_BITS-1:0]       x;
        logic [COORD_BITS-1:0]       y;
        logic [COORD_BITS-1:0]       w;
        logic [COORD_BITS-1:0]       h;
        logic [blr_pkg::CLASS_W-1:0] cls;
    } t_entry;

    // left, right, top, bottom; edges one bit wider so they never wrap
    function automatic logic [KEY_W-1:0] f_key(input t_entry e);
        f_key = {e.x, {1'b0, e.x} + {1'b0, e.w}, e.y, {1'b0, e.y} + {1'b0, e.h}};
    endfunction

    t_entry               r_ent [MAX_BOXES];
    t_entry               n_ent [MAX_BOXES];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_drop;
    logic                 n_drop;
    t_entry               w_new;
    logic [KEY_W-1:0]     w_new_key;
    logic [MAX_BOXES-1:0] w_gt;
    logic                 w_full;
    logic                 w_write;

    assign w_new.x   = COORD_BITS'(i_box.box_x);
    assign w_new.y   = COORD_BITS'(i_box.box_y);
    assign w_new.w   = COORD_BITS'(i_box.box_width);
    assign w_new.h   = COORD_BITS'(i_box.box_height);
    assign w_new.cls = i_box.class_id;
    assign w_new_key = f_key(w_new);

    assign w_full  = (r_count == CNT_W'(MAX_BOXES));
    assign w_write = i_cmd.ins && !w_full;

    // one compare cell per entry; stored entries that sort after the new box move up
    for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
        assign w_gt[i] = (CNT_W'(i) < r_count) && (w_new_key < f_key(r_ent[i]));

        always_comb begin
            n_ent[i] = r_ent[i];
            if (i_cmd.pop) begin
                if (i < MAX_BOXES - 1) begin
                    n_ent[i] = r_ent[(i < MAX_BOXES - 1) ? i + 1 : i];
                end
            end else if (w_write) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    n_ent[i] = r_ent[(i > 0) ? i - 1 : 0];
                end else if (w_gt[i] || !(CNT_W'(i) < r_count)) begin
                    n_ent[i] = w_new;
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
            if (o_status.one) begin
                n_drop = 1'b0;
            end
        end else if (i_cmd.ins) begin
            if (w_full) begin
                n_drop = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int unsigned k = 0; k < MAX_BOXES; k++) begin
            r_ent[k] <= n_ent[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

    assign o_status.one = (r_count == CNT_W'(1));

    assign o_box.out_x      = blr_pkg::BOX_COORD_W'(r_ent[0].x);
    assign o_box.out_y      = blr_pkg::BOX_COORD_W'(r_ent[0].y);
    assign o_box.out_width  = blr_pkg::BOX_COORD_W'(r_ent[0].w);
    assign o_box.out_height = blr_pkg::BOX_COORD_W'(r_ent[0].h);
    assign o_box.out_class  = r_ent[0].cls;
    assign o_box.out_last   = o_status.one;
    assign o_box.overflowed = r_drop;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BOXES))
        else $error("entry count beyond capacity");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_count != '0)
        else $error("store drained while empty");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins && !i_cmd.pop && !w_full) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the store");

    a_drop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins && w_full) |=> r_drop)
        else $error("dropped word not flagged");

endmodule

`default_nettype wire
